/* rtl/cia_pkg.sv */
`default_nettype none
package cia_pkg;
  typedef enum logic [1:0] {
    FN_CYCLE = 2'd0,
    FN_READ  = 2'd1,
    FN_WRITE = 2'd2,
    FN_TICK  = 2'd3
  } func_t;

  localparam logic [3:0] REG_PRA   = 4'd0;
  localparam logic [3:0] REG_PRB   = 4'd1;
  localparam logic [3:0] REG_DDRA  = 4'd2;
  localparam logic [3:0] REG_DDRB  = 4'd3;
  localparam logic [3:0] REG_TALO  = 4'd4;
  localparam logic [3:0] REG_TAHI  = 4'd5;
  localparam logic [3:0] REG_TBLO  = 4'd6;
  localparam logic [3:0] REG_TBHI  = 4'd7;
  localparam logic [3:0] REG_TOD10 = 4'd8;
  localparam logic [3:0] REG_TODS  = 4'd9;
  localparam logic [3:0] REG_TODM  = 4'd10;
  localparam logic [3:0] REG_TODH  = 4'd11;
  localparam logic [3:0] REG_SDR   = 4'd12;
  localparam logic [3:0] REG_ICR   = 4'd13;
  localparam logic [3:0] REG_CRA   = 4'd14;
  localparam logic [3:0] REG_CRB   = 4'd15;

  localparam logic [2:0] PH_STOP            = 3'd0;
  localparam logic [2:0] PH_WAIT_COUNT      = 3'd1;
  localparam logic [2:0] PH_LOAD_STOP       = 3'd2;
  localparam logic [2:0] PH_LOAD_COUNT      = 3'd3;
  localparam logic [2:0] PH_LOAD_WAIT_COUNT = 3'd4;
  localparam logic [2:0] PH_COUNT           = 3'd5;
  localparam logic [2:0] PH_COUNT_STOP      = 3'd6;

  typedef struct packed {
    logic [15:0] cnt;
    logic [7:0]  ctl;
    logic [8:0]  pend;
    logic [2:0]  ph;
    logic        late;
    logic        src;
    logic        uf;
  } tmr_t;

  typedef struct packed {
    logic [15:0] cnt;
    logic [15:0] rel;
    logic [7:0]  ctl;
    logic [8:0]  pend;
    logic [2:0]  ph;
    logic        may_count;
  } tmr_in_t;

  function automatic tmr_t tmr_cycle(input tmr_in_t t);
    tmr_t   r;
    logic   counting;
    logic   fire;
    logic [7:0] nc;
    r.cnt = t.cnt; r.ctl = t.ctl; r.pend = t.pend; r.ph = t.ph;
    r.late = 1'b0; r.src = 1'b0; r.uf = 1'b0;
    counting = 1'b0; fire = 1'b0;
    case (t.ph)
      PH_WAIT_COUNT: r.ph = PH_COUNT;
      PH_LOAD_STOP: begin r.ph = PH_STOP; r.cnt = t.rel; end
      PH_LOAD_COUNT: begin r.ph = PH_COUNT; r.cnt = t.rel; end
      PH_LOAD_WAIT_COUNT: begin
        r.ph = PH_WAIT_COUNT;
        if (t.cnt == 16'd1) fire = 1'b1;
        else r.cnt = t.rel;
      end
      PH_COUNT: counting = 1'b1;
      PH_COUNT_STOP: begin r.ph = PH_STOP; counting = 1'b1; end
      default: ;
    endcase
    if (counting && t.may_count) begin
      if (r.cnt != 16'd0) r.cnt = r.cnt - 16'd1;
      if (r.cnt == 16'd0) begin
        if (r.ph != PH_STOP) fire = 1'b1;
        r.uf = 1'b1;
      end
    end
    if (fire) begin
      r.cnt = t.rel; r.late = 1'b1; r.src = 1'b1; r.uf = 1'b1;
      if (r.ctl[3]) begin
        r.ctl[0] = 1'b0; r.pend[0] = 1'b0; r.ph = PH_LOAD_STOP;
      end else begin
        r.ph = PH_LOAD_COUNT;
      end
    end
    if (r.pend[8]) begin
      nc = r.pend[7:0];
      case (r.ph)
        PH_STOP, PH_LOAD_STOP: begin
          if (nc[0]) r.ph = nc[4] ? PH_LOAD_WAIT_COUNT : PH_WAIT_COUNT;
          else if (nc[4]) r.ph = PH_LOAD_STOP;
        end
        PH_COUNT: begin
          if (nc[0]) begin
            if (nc[4]) r.ph = PH_LOAD_WAIT_COUNT;
          end else begin
            r.ph = nc[4] ? PH_LOAD_STOP : PH_COUNT_STOP;
          end
        end
        PH_LOAD_COUNT, PH_WAIT_COUNT: begin
          if (nc[0]) begin
            if (nc[3]) begin nc[0] = 1'b0; r.ph = PH_STOP; end
            else if (nc[4]) r.ph = PH_LOAD_WAIT_COUNT;
          end else begin
            r.ph = PH_STOP;
          end
        end
        default: ;
      endcase
      r.ctl = nc & 8'hef;
      r.pend = 9'd0;
    end
    return r;
  endfunction

  // bcd 00..59 increment, carry out on wrap
  function automatic logic [8:0] bcd_step(input logic [7:0] v);
    logic [4:0] lo;
    logic [3:0] hi;
    lo = {1'b0, v[3:0]} + 5'd1;
    hi = v[7:4];
    if (lo > 5'd9) begin lo = 5'd0; hi = hi + 4'd1; end
    if (hi > 4'd5) return {1'b1, 8'h00};
    return {1'b0, hi, lo[3:0]};
  endfunction
endpackage
`default_nettype wire

/* rtl/cia_timer_tod_interrupt_unit.sv */
// an accepted item's result is registered in the output register, or the skid entry if it stalls
// throughput: one item per clock while the skid entry is free; the whole update is one combinational pass
// from the state registers to their next values, set by the two timer chains
// output register with a skid: a new item is taken while a result waits
// rst_n synchronous active low; all state but the result and skid data returns to its power-up values
`default_nettype none
module cia_timer_tod_interrupt_unit (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [15:0] in_tdata,   // func[1:0], addr[5:2], wdata[13:6], zero[15:14]
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [15:0] out_tdata  // rdata[7:0], irq[8], zero[15:9]
);
  import cia_pkg::*;

  logic [7:0]  port_a_r, port_b_r, dir_a_r, dir_b_r;
  logic [15:0] count_a_r, count_b_r, reload_a_r, reload_b_r;
  logic [7:0]  control_a_r, control_b_r;
  logic [8:0]  pend_a_r, pend_b_r;
  logic [2:0]  phase_a_r, phase_b_r;
  logic [2:0]  src_r;
  logic [1:0]  late_r;
  logic [7:0]  clk_t_r [4];
  logic [7:0]  alm_t_r [4];
  logic [2:0]  div_r;
  logic        hold_r;
  logic [7:0]  sdr_r, icr_r, ier_r;

  logic [7:0]  port_a_nxt, port_b_nxt, dir_a_nxt, dir_b_nxt;
  logic [15:0] count_a_nxt, count_b_nxt, reload_a_nxt, reload_b_nxt;
  logic [7:0]  control_a_nxt, control_b_nxt;
  logic [8:0]  pend_a_nxt, pend_b_nxt;
  logic [2:0]  phase_a_nxt, phase_b_nxt;
  logic [2:0]  src_nxt;
  logic [1:0]  late_nxt;
  logic [7:0]  clk_t_nxt [4];
  logic [7:0]  alm_t_nxt [4];
  logic [2:0]  div_nxt;
  logic        hold_nxt;
  logic [7:0]  sdr_nxt, icr_nxt, ier_nxt;
  logic [7:0]  rdata;

  // output stage with one skid entry
  logic        out_v_r, skid_v_r;
  logic [8:0]  out_d_r, skid_d_r;

  logic [1:0]  func;
  logic [3:0]  addr;
  logic [7:0]  wdata;
  logic        acc;
  tmr_in_t     ta_in, tb_in;
  tmr_t        ta, tb;
  logic [8:0]  st_s, st_m;
  logic [4:0]  hlo;
  logic [1:0]  hhi;
  logic [7:0]  hr;
  logic [7:0]  tmask;

  assign func  = in_tdata[1:0];
  assign addr  = in_tdata[5:2];
  assign wdata = in_tdata[13:6];
  assign in_tready = !skid_v_r;
  assign acc = in_tvalid && in_tready;

  // timer chains: late flags raise first, then A, then B which may count A underflows
  always_comb begin
    logic [7:0] ist;
    ist = icr_r;
    if (late_r[0]) begin ist[0] = 1'b1; if (ier_r[0]) ist[7] = 1'b1; end
    if (late_r[1]) begin ist[1] = 1'b1; if (ier_r[1]) ist[7] = 1'b1; end
    ta_in = '{cnt: count_a_r, rel: reload_a_r, ctl: control_a_r, pend: pend_a_r,
              ph: phase_a_r, may_count: src_r[0]};
    ta = tmr_cycle(ta_in);
    tb_in = '{cnt: count_b_r, rel: reload_b_r, ctl: control_b_r, pend: pend_b_r,
              ph: phase_b_r, may_count: src_r[1] || (src_r[2] && ta.uf)};
    tb = tmr_cycle(tb_in);
    st_s = bcd_step(clk_t_r[1]);
    st_m = bcd_step(clk_t_r[2]);
    // hour tens may carry into bit 5; only the low five bits decide the wrap
    hlo = {1'b0, clk_t_r[3][3:0]} + 5'd1;
    hhi = {1'b0, clk_t_r[3][4]};
    if (hlo > 5'd9) begin hlo = 5'd0; hhi = hhi + 2'd1; end
    hr = {clk_t_r[3][7], 1'b0, hhi, hlo[3:0]};
    if (hr[4:0] > 5'h11) hr = {~clk_t_r[3][7], 7'd0};

    case (addr[1:0])
      2'd0:    tmask = 8'h0f;
      2'd1:    tmask = 8'h7f;
      2'd2:    tmask = 8'h7f;
      default: tmask = 8'h9f;
    endcase

    port_a_nxt = port_a_r; port_b_nxt = port_b_r;
    dir_a_nxt = dir_a_r; dir_b_nxt = dir_b_r;
    count_a_nxt = count_a_r; count_b_nxt = count_b_r;
    reload_a_nxt = reload_a_r; reload_b_nxt = reload_b_r;
    control_a_nxt = control_a_r; control_b_nxt = control_b_r;
    pend_a_nxt = pend_a_r; pend_b_nxt = pend_b_r;
    phase_a_nxt = phase_a_r; phase_b_nxt = phase_b_r;
    src_nxt = src_r; late_nxt = late_r;
    clk_t_nxt = clk_t_r; alm_t_nxt = alm_t_r;
    div_nxt = div_r; hold_nxt = hold_r;
    sdr_nxt = sdr_r; icr_nxt = icr_r; ier_nxt = ier_r;
    rdata = 8'd0;

    case (func)
      FN_CYCLE: begin
        count_a_nxt = ta.cnt; control_a_nxt = ta.ctl;
        pend_a_nxt = ta.pend; phase_a_nxt = ta.ph;
        count_b_nxt = tb.cnt; control_b_nxt = tb.ctl;
        pend_b_nxt = tb.pend; phase_b_nxt = tb.ph;
        late_nxt = {tb.late, ta.late};
        icr_nxt = ist | {6'd0, tb.src, ta.src};
      end
      FN_READ: begin
        unique case (addr)
          REG_PRA:   rdata = port_a_r | ~dir_a_r;
          REG_PRB:   rdata = port_b_r | ~dir_b_r;
          REG_DDRA:  rdata = dir_a_r;
          REG_DDRB:  rdata = dir_b_r;
          REG_TALO:  rdata = count_a_r[7:0];
          REG_TAHI:  rdata = count_a_r[15:8];
          REG_TBLO:  rdata = count_b_r[7:0];
          REG_TBHI:  rdata = count_b_r[15:8];
          REG_TOD10: begin hold_nxt = 1'b0; rdata = clk_t_r[0]; end
          REG_TODS:  rdata = clk_t_r[1];
          REG_TODM:  rdata = clk_t_r[2];
          REG_TODH:  begin hold_nxt = 1'b1; rdata = clk_t_r[3]; end
          REG_SDR:   rdata = sdr_r;
          REG_ICR:   begin rdata = icr_r; icr_nxt = 8'd0; end
          REG_CRA:   rdata = control_a_r;
          REG_CRB:   rdata = control_b_r;
          default:   rdata = 8'd0;
        endcase
      end
      FN_WRITE: begin
        unique case (addr)
          REG_PRA:  port_a_nxt = wdata;
          REG_PRB:  port_b_nxt = wdata;
          REG_DDRA: dir_a_nxt = wdata;
          REG_DDRB: dir_b_nxt = wdata;
          REG_TALO: reload_a_nxt[7:0] = wdata;
          REG_TAHI: begin
            reload_a_nxt[15:8] = wdata;
            if (!control_a_r[0]) count_a_nxt = {wdata, reload_a_r[7:0]};
          end
          REG_TBLO: reload_b_nxt[7:0] = wdata;
          REG_TBHI: begin
            reload_b_nxt[15:8] = wdata;
            if (!control_b_r[0]) count_b_nxt = {wdata, reload_b_r[7:0]};
          end
          REG_TOD10, REG_TODS, REG_TODM, REG_TODH: begin
            if (control_b_r[7]) alm_t_nxt[addr[1:0]] = wdata & tmask;
            else clk_t_nxt[addr[1:0]] = wdata & tmask;
          end
          REG_SDR: begin
            sdr_nxt = wdata;
            icr_nxt[3] = 1'b1;
            if (ier_r[3]) icr_nxt[7] = 1'b1;
          end
          REG_ICR: begin
            if (wdata[7]) ier_nxt = ier_r | {1'b0, wdata[6:0]};
            else ier_nxt = ier_r & ~wdata;
            if ((icr_r[4:0] & ier_nxt[4:0]) != 5'd0) icr_nxt[7] = 1'b1;
          end
          REG_CRA: begin
            pend_a_nxt = {1'b1, wdata};
            src_nxt[0] = !wdata[5];
          end
          REG_CRB: begin
            pend_b_nxt = {1'b1, wdata};
            src_nxt[1] = (wdata[6:5] == 2'b00);
            src_nxt[2] = (wdata[6:5] == 2'b10);
          end
          default: ;
        endcase
      end
      default: begin
        // time-of-day tick through the 5/6 prescaler
        if (!hold_r) begin
          if (div_r != 3'd0) begin
            div_nxt = div_r - 3'd1;
          end else begin
            div_nxt = control_a_r[7] ? 3'd4 : 3'd5;
            clk_t_nxt[0] = clk_t_r[0] + 8'd1;
            if (clk_t_nxt[0] > 8'd9) begin
              clk_t_nxt[0] = 8'd0;
              clk_t_nxt[1] = st_s[7:0];
              if (st_s[8]) begin
                clk_t_nxt[2] = st_m[7:0];
                if (st_m[8]) clk_t_nxt[3] = hr;
              end
            end
            if (clk_t_nxt[0] == alm_t_r[0] && clk_t_nxt[1] == alm_t_r[1] &&
                clk_t_nxt[2] == alm_t_r[2] && clk_t_nxt[3] == alm_t_r[3]) begin
              icr_nxt[2] = 1'b1;
              if (ier_r[2]) icr_nxt[7] = 1'b1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_a_r <= 8'd0; port_b_r <= 8'd0; dir_a_r <= 8'd0; dir_b_r <= 8'd0;
      count_a_r <= 16'hffff; count_b_r <= 16'hffff;
      reload_a_r <= 16'd1; reload_b_r <= 16'd1;
      control_a_r <= 8'd0; control_b_r <= 8'd0;
      pend_a_r <= 9'd0; pend_b_r <= 9'd0;
      phase_a_r <= PH_STOP; phase_b_r <= PH_STOP;
      src_r <= 3'd0; late_r <= 2'd0;
      for (int i = 0; i < 4; i++) begin clk_t_r[i] <= 8'd0; alm_t_r[i] <= 8'd0; end
      div_r <= 3'd0; hold_r <= 1'b0;
      sdr_r <= 8'd0; icr_r <= 8'd0; ier_r <= 8'd0;
    end else if (acc) begin
      port_a_r <= port_a_nxt; port_b_r <= port_b_nxt;
      dir_a_r <= dir_a_nxt; dir_b_r <= dir_b_nxt;
      count_a_r <= count_a_nxt; count_b_r <= count_b_nxt;
      reload_a_r <= reload_a_nxt; reload_b_r <= reload_b_nxt;
      control_a_r <= control_a_nxt; control_b_r <= control_b_nxt;
      pend_a_r <= pend_a_nxt; pend_b_r <= pend_b_nxt;
      phase_a_r <= phase_a_nxt; phase_b_r <= phase_b_nxt;
      src_r <= src_nxt; late_r <= late_nxt;
      clk_t_r <= clk_t_nxt; alm_t_r <= alm_t_nxt;
      div_r <= div_nxt; hold_r <= hold_nxt;
      sdr_r <= sdr_nxt; icr_r <= icr_nxt; ier_r <= ier_nxt;
    end
  end

  // result register plus skid: a new result parks in the skid entry while output stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (out_v_r && !out_tready) begin
        if (acc) begin
          skid_v_r <= 1'b1;
          skid_d_r <= {icr_nxt[7], rdata};
        end
      end else if (skid_v_r) begin
        out_v_r <= 1'b1;
        out_d_r <= skid_d_r;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= acc;
        if (acc) out_d_r <= {icr_nxt[7], rdata};
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_d_r};

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds an item with empty output");
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> !skid_v_r) else $error("skid did not drain");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> (out_v_r && $stable(out_d_r)))
    else $error("stalled result changed");
  a_irq_needs_src: assert property (@(posedge clk) disable iff (!rst_n)
    (icr_r[7] && !$past(icr_r[7]) && $past(acc)) |-> (icr_r[4:0] != 5'd0))
    else $error("interrupt raised with no source");
`endif
endmodule
`default_nettype wire

/* tb/cia_timer_tod_interrupt_unit_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module cia_timer_tod_interrupt_unit_checker
  import cia_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [15:0] in_tdata,
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [15:0] out_tdata,
  output int         fail_count,
  output int         pending_results,
  output int         irq_seen
);
  logic [7:0]  pa, pb, da, db, ctl_a, ctl_b, sdr, icr, imask;
  logic [15:0] cnt_a, cnt_b, lat_a, lat_b;
  logic [8:0]  pnd_a, pnd_b;
  logic [2:0]  ph_a, ph_b, srcsel;
  logic [1:0]  late;
  logic [7:0]  tod [4];
  logic [7:0]  alm [4];
  logic [2:0]  div;
  logic        hold;
  logic [8:0]  expected_q [$];

  function automatic logic [8:0] bcd_inc(input logic [7:0] v);
    logic [4:0] lo;
    logic [3:0] hi;
    lo = {1'b0, v[3:0]} + 5'd1;
    hi = v[7:4];
    if (lo > 5'd9) begin
      lo = 5'd0;
      hi = hi + 4'd1;
    end
    if (hi > 4'd5) return 9'h100;
    return {1'b0, hi, lo[3:0]};
  endfunction

  function automatic void raise(input logic [7:0] b);
    icr = icr | b;
    if ((imask & b) != 0) icr[7] = 1'b1;
  endfunction

  function automatic void step_timer(inout logic [15:0] c, input logic [15:0] rel,
                                     inout logic [7:0] ct, inout logic [8:0] pe,
                                     inout logic [2:0] ph, input logic may,
                                     input int idx, output logic uf);
    logic counting, fire;
    logic [7:0] nc;
    counting = 0;
    fire = 0;
    uf = 0;
    case (ph)
      PH_WAIT_COUNT: ph = PH_COUNT;
      PH_LOAD_STOP: begin
        ph = PH_STOP;
        c = rel;
      end
      PH_LOAD_COUNT: begin
        ph = PH_COUNT;
        c = rel;
      end
      PH_LOAD_WAIT_COUNT: begin
        ph = PH_WAIT_COUNT;
        if (c == 16'd1) fire = 1;
        else c = rel;
      end
      PH_COUNT: counting = 1;
      PH_COUNT_STOP: begin
        ph = PH_STOP;
        counting = 1;
      end
      default: ;
    endcase
    if (counting && may) begin
      if (c != 0) c = c - 16'd1;
      if (c == 0) begin
        if (ph != PH_STOP) fire = 1;
        uf = 1;
      end
    end
    if (fire) begin
      c = rel;
      late[idx] = 1'b1;
      icr[idx] = 1'b1;
      if (ct[3]) begin
        ct[0] = 0;
        pe[0] = 0;
        ph = PH_LOAD_STOP;
      end else begin
        ph = PH_LOAD_COUNT;
      end
      uf = 1;
    end
    if (pe[8]) begin
      nc = pe[7:0];
      case (ph)
        PH_STOP, PH_LOAD_STOP: begin
          if (nc[0]) ph = nc[4] ? PH_LOAD_WAIT_COUNT : PH_WAIT_COUNT;
          else if (nc[4]) ph = PH_LOAD_STOP;
        end
        PH_COUNT: begin
          if (nc[0]) begin
            if (nc[4]) ph = PH_LOAD_WAIT_COUNT;
          end else begin
            ph = nc[4] ? PH_LOAD_STOP : PH_COUNT_STOP;
          end
        end
        PH_LOAD_COUNT, PH_WAIT_COUNT: begin
          if (nc[0]) begin
            if (nc[3]) begin
              nc[0] = 0;
              ph = PH_STOP;
            end else if (nc[4]) begin
              ph = PH_LOAD_WAIT_COUNT;
            end
          end else begin
            ph = PH_STOP;
          end
        end
        default: ;
      endcase
      ct = nc & 8'hef;
      pe = 0;
    end
  endfunction

  function automatic void tod_tick();
    logic [8:0] r;
    logic [7:0] h;
    logic [3:0] lo;
    logic [1:0] hi;
    if (hold) return;
    if (div != 0) begin
      div = div - 3'd1;
      return;
    end
    div = ctl_a[7] ? 3'd4 : 3'd5;
    tod[0] = tod[0] + 8'd1;
    if (tod[0] > 8'd9) begin
      tod[0] = 0;
      r = bcd_inc(tod[1]);
      tod[1] = r[7:0];
      if (r[8]) begin
        r = bcd_inc(tod[2]);
        tod[2] = r[7:0];
        if (r[8]) begin
          h = tod[3];
          lo = h[3:0] + 4'd1;
          hi = {1'b0, h[4]};
          if (h[3:0] + 5'd1 > 5'd9) begin
            lo = 0;
            hi = hi + 2'd1;
          end
          h = {h[7], 1'b0, hi, lo};
          if ((h & 8'h1f) > 8'h11) h = (h & 8'h80) ^ 8'h80;
          tod[3] = h;
        end
      end
    end
    if (tod[0] == alm[0] && tod[1] == alm[1] && tod[2] == alm[2] && tod[3] == alm[3])
      raise(8'h04);
  endfunction

  // works out the result of one item and updates the shadow state
  function automatic logic [8:0] adapter_step(input func_t fn, input logic [3:0] a,
                                              input logic [7:0] v);
    logic [7:0] rd;
    logic       ufa, ufb;
    rd = 0;
    case (fn)
      FN_CYCLE: begin
        if (late[0]) begin
          late[0] = 0;
          raise(8'h01);
        end
        if (late[1]) begin
          late[1] = 0;
          raise(8'h02);
        end
        step_timer(cnt_a, lat_a, ctl_a, pnd_a, ph_a, srcsel[0], 0, ufa);
        step_timer(cnt_b, lat_b, ctl_b, pnd_b, ph_b, srcsel[1] || (srcsel[2] && ufa),
                   1, ufb);
      end
      FN_READ: begin
        case (a)
          REG_PRA:   rd = pa | ~da;
          REG_PRB:   rd = pb | ~db;
          REG_DDRA:  rd = da;
          REG_DDRB:  rd = db;
          REG_TALO:  rd = cnt_a[7:0];
          REG_TAHI:  rd = cnt_a[15:8];
          REG_TBLO:  rd = cnt_b[7:0];
          REG_TBHI:  rd = cnt_b[15:8];
          REG_TOD10: begin
            hold = 0;
            rd = tod[0];
          end
          REG_TODS:  rd = tod[1];
          REG_TODM:  rd = tod[2];
          REG_TODH: begin
            hold = 1;
            rd = tod[3];
          end
          REG_SDR:   rd = sdr;
          REG_ICR: begin
            rd = icr;
            icr = 0;
          end
          REG_CRA:   rd = ctl_a;
          default:   rd = ctl_b;
        endcase
      end
      FN_WRITE: begin
        case (a)
          REG_PRA:  pa = v;
          REG_PRB:  pb = v;
          REG_DDRA: da = v;
          REG_DDRB: db = v;
          REG_TALO: lat_a[7:0] = v;
          REG_TAHI: begin
            lat_a[15:8] = v;
            if (!ctl_a[0]) cnt_a = lat_a;
          end
          REG_TBLO: lat_b[7:0] = v;
          REG_TBHI: begin
            lat_b[15:8] = v;
            if (!ctl_b[0]) cnt_b = lat_b;
          end
          REG_TOD10, REG_TODS, REG_TODM, REG_TODH: begin
            logic [7:0] m;
            m = (a == REG_TOD10) ? 8'h0f : (a == REG_TODH) ? 8'h9f : 8'h7f;
            if (ctl_b[7]) alm[a[1:0]] = v & m;
            else tod[a[1:0]] = v & m;
          end
          REG_SDR: begin
            sdr = v;
            raise(8'h08);
          end
          REG_ICR: begin
            if (v[7]) imask = imask | (v & 8'h7f);
            else imask = imask & ~v;
            if ((icr & imask & 8'h1f) != 0) icr[7] = 1'b1;
          end
          REG_CRA: begin
            pnd_a = {1'b1, v};
            srcsel[0] = !v[5];
          end
          default: begin
            pnd_b = {1'b1, v};
            srcsel[1] = (v[6:5] == 2'b00);
            srcsel[2] = (v[6:5] == 2'b10);
          end
        endcase
      end
      default: tod_tick();
    endcase
    return {icr[7], rd};
  endfunction

  assign pending_results = expected_q.size();

  always @(posedge clk) begin
    logic [8:0] exp_r;
    if (!rst_n) begin
      pa <= 0; pb <= 0; da <= 0; db <= 0;
      cnt_a <= 16'hffff; cnt_b <= 16'hffff; lat_a <= 1; lat_b <= 1;
      ctl_a <= 0; ctl_b <= 0; pnd_a <= 0; pnd_b <= 0;
      ph_a <= PH_STOP; ph_b <= PH_STOP; srcsel <= 0; late <= 0;
      for (int i = 0; i < 4; i++) begin
        tod[i] = 0;
        alm[i] = 0;
      end
      div <= 0; hold <= 0; sdr <= 0; icr <= 0; imask <= 0;
      expected_q.delete();
      fail_count <= 0;
      irq_seen <= 0;
    end else begin
      // result side first: an accepted item's result passes a register before output
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_tdata[8] != exp_r[8] || out_tdata[7:0] != exp_r[7:0] ||
              out_tdata[15:9] != 0) begin
            if (fail_count < 10)
              $display("mismatch: rdata exp %h got %h, irq exp %b got %b",
                       exp_r[7:0], out_tdata[7:0], exp_r[8], out_tdata[8]);
            fail_count <= fail_count + 1;
          end
          if (exp_r[8]) irq_seen <= irq_seen + 1;
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(adapter_step(func_t'(in_tdata[1:0]), in_tdata[5:2],
                                          in_tdata[13:6]));
    end
  end
endmodule
`default_nettype wire

/* tb/cia_timer_tod_interrupt_unit_test.sv */
`timescale 1ns / 1ps
`default_nettype none
module cia_timer_tod_interrupt_unit_test;
  import cia_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = 0;   // func[1:0], addr[5:2], wdata[13:6], zero[15:14]
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;      // rdata[7:0], irq[8], zero[15:9]
  int          fail_count, pending_results, irq_seen;
  int          src_idle_pct = 0, snk_stall_pct = 0;
  int          hold_off = 0;   // long receiver stall, in cycles
  int          idle_cycles = 0, items_sent = 0;

  always #1 clk = ~clk;

  cia_timer_tod_interrupt_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  cia_timer_tod_interrupt_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_results(pending_results), .irq_seen(irq_seen)
  );

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watchdog: cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // offer one item, with random idle gaps before it, and wait for acceptance
  task automatic send_item(input func_t fn, input logic [3:0] a, input logic [7:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, v, a, fn};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // mostly clock cycles and timer/interrupt traffic, with random register access
  task automatic random_item();
    int pick;
    logic [3:0] a;
    logic [7:0] v;
    pick = $urandom_range(99);
    a = 4'($urandom_range(15));
    v = 8'($urandom_range(255));
    if (pick < 40) send_item(FN_CYCLE, a, v);
    else if (pick < 55) send_item(FN_TICK, a, v);
    else if (pick < 75) send_item(FN_READ, a, v);
    else if (pick < 85) begin
      // small timer latches so underflows happen often
      a = 4'($urandom_range(REG_TBHI, REG_TALO));
      if (a[0]) v = $urandom_range(3) == 0 ? v : 8'h00;
      else v = 8'($urandom_range(12));
      send_item(FN_WRITE, a, v);
    end else if (pick < 92) begin
      a = $urandom_range(1) ? REG_CRA : REG_CRB;
      send_item(FN_WRITE, a, v);
    end else begin
      send_item(FN_WRITE, a, v);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ports, timers in continuous and one-shot mode, b counting a,
    // interrupt mask set and clear, serial write, clock set, hold, hour wrap
    send_item(FN_WRITE, REG_DDRA, 8'hff);
    send_item(FN_WRITE, REG_PRA, 8'h5a);
    send_item(FN_READ, REG_PRA, 8'h00);
    send_item(FN_READ, REG_PRB, 8'h00);
    send_item(FN_WRITE, REG_ICR, 8'hff);
    send_item(FN_WRITE, REG_TALO, 8'h02);
    send_item(FN_WRITE, REG_TAHI, 8'h00);
    send_item(FN_WRITE, REG_CRA, 8'h19);
    send_item(FN_WRITE, REG_CRB, 8'h51);
    repeat (8) send_item(FN_CYCLE, 4'd0, 8'h00);
    send_item(FN_READ, REG_ICR, 8'h00);
    send_item(FN_WRITE, REG_SDR, 8'hff);
    send_item(FN_WRITE, REG_TODH, 8'h11);
    send_item(FN_WRITE, REG_TODM, 8'h59);
    send_item(FN_WRITE, REG_TODS, 8'h59);
    send_item(FN_WRITE, REG_TOD10, 8'h09);
    send_item(FN_READ, REG_TODH, 8'h00);
    send_item(FN_TICK, 4'd0, 8'h00);
    send_item(FN_READ, REG_TOD10, 8'h00);
    repeat (7) send_item(FN_TICK, 4'd0, 8'h00);
    send_item(FN_READ, REG_TODH, 8'h00);
    send_item(FN_WRITE, REG_ICR, 8'h7f);

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 26 : 86) : 0;
      snk_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 26 : 86) : 0;
      if (ph == 0) hold_off <= 60;
      for (int i = 0; i < 350; i++) begin
        if (i == 175) begin
          // alarm setup mid-phase: alarm bit set in control b, then clock back
          send_item(FN_WRITE, REG_CRB, 8'h80);
          send_item(FN_WRITE, REG_TOD10, 8'($urandom_range(15)));
          send_item(FN_WRITE, REG_CRB, 8'h00);
          send_item(FN_WRITE, REG_ICR, 8'h84);
        end
        random_item();
      end
    end
    in_tvalid <= 1'b0;

    src_idle_pct = 0;
    snk_stall_pct = 0;
    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("ran %0d items over four idling phases; %0d results with irq high",
             items_sent, irq_seen);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

/* cia_timer_tod_interrupt_unit.f */
rtl/cia_pkg.sv
rtl/cia_timer_tod_interrupt_unit.sv
tb/cia_timer_tod_interrupt_unit_checker.sv
tb/cia_timer_tod_interrupt_unit_test.sv
